// ----- src/qcs_pkg.sv -----
// ----------------------------------------------------------------------------
// qcs_pkg: shared types and constants of the quarter-car suspension core
// Step codes, controller states, command and status bundles, register
// indexes and the quarter-wave sine builder used at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package qcs_pkg;

  localparam longint unsigned PI_Q30   = 64'd3373259426;
  localparam int unsigned     BUMP_AMP = 52429;

  typedef enum logic [2:0] {
    CFG_INV_SPRUNG_MASS   = 3'd0,
    CFG_INV_UNSPRUNG_MASS = 3'd1,
    CFG_SPRING_STIFFNESS  = 3'd2,
    CFG_DAMPER_COEFF      = 3'd3,
    CFG_TYRE_STIFFNESS    = 3'd4,
    CFG_TRAVEL_SPEED      = 3'd5,
    CFG_BUMP_START_TIME   = 3'd6,
    CFG_BUMP_INV_DURATION = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_PH, OP_FS1, OP_SCALE, OP_FS2, OP_RDA, OP_RDB, OP_INTERP,
    OP_TRAV, OP_AMP, OP_EUL0, OP_TYRE, OP_EUL2, OP_ABHI, OP_ABLO, OP_AWHI,
    OP_AWLO, OP_EUL1, OP_EUL3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PH, ST_FS1, ST_SCALE, ST_FS2, ST_RDA, ST_RDB, ST_INTERP,
    ST_TRAV, ST_AMP, ST_EUL0, ST_TYRE, ST_EUL2, ST_ABHI, ST_ABLO, ST_AWHI,
    ST_AWLO, ST_EUL1, ST_EUL3, ST_WB, ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
  } ctrl_sts_t;

  // Eight-term Taylor series of the sine in Q30, each term truncated,
  // then rounded half up to Q1.20.
  function automatic logic [20:0] sine_q20(input longint unsigned x);
    longint unsigned term;
    longint          sum;
    longint unsigned res;
    term = x;
    sum  = longint'(x);
    term = ((((term * x) >> 30) * x) >> 30) / 6;   sum = sum - longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 20;  sum = sum + longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 42;  sum = sum - longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 72;  sum = sum + longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 110; sum = sum - longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 156; sum = sum + longint'(term);
    term = ((((term * x) >> 30) * x) >> 30) / 210; sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    res = (unsigned'(sum) + 64'd512) >> 10;
    return res[20:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/qcs_in_if.sv -----
// ----------------------------------------------------------------------------
// qcs_in_if: input channel
// Valid/ready channel carrying a sample time and an integration step.
// ----------------------------------------------------------------------------
`default_nettype none

interface qcs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time;
  logic [19:0] time_step;

  modport source (output valid, output sample_time, output time_step, input ready);
  modport sink   (input valid, input sample_time, input time_step, output ready);
endinterface

`default_nettype wire

// ----- src/qcs_out_if.sv -----
// ----------------------------------------------------------------------------
// qcs_out_if: result channel
// Valid/ready channel carrying the new suspension state and road height.
// ----------------------------------------------------------------------------
`default_nettype none

interface qcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] body_position;
  logic signed [31:0] body_velocity;
  logic signed [31:0] body_acceleration;
  logic signed [31:0] wheel_position;
  logic signed [31:0] wheel_velocity;
  logic signed [31:0] wheel_acceleration;
  logic signed [31:0] road_height;
  logic        [47:0] travel_distance;

  modport source (output valid, output body_position, output body_velocity,
                  output body_acceleration, output wheel_position,
                  output wheel_velocity, output wheel_acceleration,
                  output road_height, output travel_distance, input ready);
  modport sink   (input valid, input body_position, input body_velocity,
                  input body_acceleration, input wheel_position,
                  input wheel_velocity, input wheel_acceleration,
                  input road_height, input travel_distance, output ready);
endinterface

`default_nettype wire

// ----- src/qcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// qcs_ctrl: step sequencer
// Walks one Euler step through the shared multiplier, one step code a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qcs_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  qcs_pkg::ctrl_sts_t  sts,
  output qcs_pkg::ctrl_cmd_t  cmd
);

  qcs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.op     = qcs_pkg::OP_NONE;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      qcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = qcs_pkg::ST_PH;
        end
      end
      qcs_pkg::ST_PH:     begin cmd.op = qcs_pkg::OP_PH;     state_nxt = qcs_pkg::ST_FS1;    end
      qcs_pkg::ST_FS1:    begin cmd.op = qcs_pkg::OP_FS1;    state_nxt = qcs_pkg::ST_SCALE;  end
      qcs_pkg::ST_SCALE:  begin cmd.op = qcs_pkg::OP_SCALE;  state_nxt = qcs_pkg::ST_FS2;    end
      qcs_pkg::ST_FS2:    begin cmd.op = qcs_pkg::OP_FS2;    state_nxt = qcs_pkg::ST_RDA;    end
      qcs_pkg::ST_RDA:    begin cmd.op = qcs_pkg::OP_RDA;    state_nxt = qcs_pkg::ST_RDB;    end
      qcs_pkg::ST_RDB:    begin cmd.op = qcs_pkg::OP_RDB;    state_nxt = qcs_pkg::ST_INTERP; end
      qcs_pkg::ST_INTERP: begin cmd.op = qcs_pkg::OP_INTERP; state_nxt = qcs_pkg::ST_TRAV;   end
      qcs_pkg::ST_TRAV:   begin cmd.op = qcs_pkg::OP_TRAV;   state_nxt = qcs_pkg::ST_AMP;    end
      qcs_pkg::ST_AMP:    begin cmd.op = qcs_pkg::OP_AMP;    state_nxt = qcs_pkg::ST_EUL0;   end
      qcs_pkg::ST_EUL0:   begin cmd.op = qcs_pkg::OP_EUL0;   state_nxt = qcs_pkg::ST_TYRE;   end
      qcs_pkg::ST_TYRE:   begin cmd.op = qcs_pkg::OP_TYRE;   state_nxt = qcs_pkg::ST_EUL2;   end
      qcs_pkg::ST_EUL2:   begin cmd.op = qcs_pkg::OP_EUL2;   state_nxt = qcs_pkg::ST_ABHI;   end
      qcs_pkg::ST_ABHI:   begin cmd.op = qcs_pkg::OP_ABHI;   state_nxt = qcs_pkg::ST_ABLO;   end
      qcs_pkg::ST_ABLO:   begin cmd.op = qcs_pkg::OP_ABLO;   state_nxt = qcs_pkg::ST_AWHI;   end
      qcs_pkg::ST_AWHI:   begin cmd.op = qcs_pkg::OP_AWHI;   state_nxt = qcs_pkg::ST_AWLO;   end
      qcs_pkg::ST_AWLO:   begin cmd.op = qcs_pkg::OP_AWLO;   state_nxt = qcs_pkg::ST_EUL1;   end
      qcs_pkg::ST_EUL1:   begin cmd.op = qcs_pkg::OP_EUL1;   state_nxt = qcs_pkg::ST_EUL3;   end
      qcs_pkg::ST_EUL3:   begin cmd.op = qcs_pkg::OP_EUL3;   state_nxt = qcs_pkg::ST_WB;     end
      qcs_pkg::ST_WB:     begin state_nxt = qcs_pkg::ST_DONE; end
      qcs_pkg::ST_DONE: begin
        // Hold the finished step until the output register has room.
        if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = qcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qcs_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/qcs_datapath.sv -----
// ----------------------------------------------------------------------------
// qcs_datapath: suspension datapath
// Configuration registers, one shared multiplier with a product register,
// write-back of each product, sine table, state and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module qcs_datapath #(
  parameter int SINE_ENTRIES = 256
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [31:0]        cfg_data,
  qcs_in_if.sink             in_chan,
  qcs_out_if.source          out_chan,
  input  qcs_pkg::ctrl_cmd_t cmd,
  output qcs_pkg::ctrl_sts_t sts
);

  localparam int IW = $clog2(2 * SINE_ENTRIES);
  localparam int AW = $clog2(SINE_ENTRIES + 1);

  // Sine table, built at elaboration.
  logic [20:0] sine_tab [SINE_ENTRIES + 1];
  for (genvar g = 0; g <= SINE_ENTRIES; g++) begin : g_sine
    localparam longint unsigned Xq = (longint'(g) * qcs_pkg::PI_Q30) / (2 * SINE_ENTRIES);
    assign sine_tab[g] = qcs_pkg::sine_q20(Xq);
  end

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = {v[31], v};
    return v[31] ? 33'(-e) : 33'(e);
  endfunction

  function automatic logic signed [31:0] euler_add(input logic signed [31:0] base,
                                                   input logic neg,
                                                   input logic [31:0] inc);
    logic signed [63:0] d;
    d = $signed({32'b0, inc});
    return sat32(64'(base) + (neg ? -d : d));
  endfunction

  // Configuration registers.
  logic [31:0] inv_sm_r, inv_usm_r, speed_r, start_r, inv_dur_r;
  logic [23:0] spring_r, damper_r, tyre_r;

  // State registers.
  logic signed [31:0] body_pos_r, body_vel_r, wheel_pos_r, wheel_vel_r;
  logic [47:0]        travel_r;
  logic               out_valid_r;
  qcs_pkg::op_t       op_q_r;

  // Working registers.
  logic [31:0]        t_r;
  logic [19:0]        dt_r;
  logic               active_r;
  logic [31:0]        p_r;
  logic [15:0]        f_r;
  logic [AW-1:0]      ia_r, ib_r;
  logic [20:0]        rd_data_r, tab_a_r, tab_b_r, sine_r;
  logic signed [31:0] zr_r;
  logic signed [63:0] fs_r, fw_r;
  logic [63:0]        hi_r;
  logic signed [31:0] ab_r, aw_r, nx0_r, nx1_r, nx2_r, nx3_r;
  logic [47:0]        trav_nx_r;
  logic signed [66:0] prod_r;

  // Output payload registers.
  logic signed [31:0] o_bp_r, o_bv_r, o_ba_r, o_wp_r, o_wv_r, o_wa_r, o_zr_r;
  logic [47:0]        o_td_r;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [32:0] d_sw, d_v, d_t;
  logic [63:0]        mag_fs, mag_fw;
  logic               t_ge;
  logic [31:0]        t_diff;
  logic [20:0]        sel_b, diff_ab;
  logic               b_ge_a;
  logic [IW:0]        seg_i, seg_m;
  logic [AW-1:0]      rd_addr;
  logic [63:0]        ab_sum, aw_sum;
  logic [40:0]        amp_rnd;
  logic [48:0]        trav_sum;

  assign d_sw   = {body_pos_r[31], body_pos_r} - {wheel_pos_r[31], wheel_pos_r};
  assign d_v    = {body_vel_r[31], body_vel_r} - {wheel_vel_r[31], wheel_vel_r};
  assign d_t    = {wheel_pos_r[31], wheel_pos_r} - {zr_r[31], zr_r};
  assign mag_fs = fs_r[63] ? 64'(-fs_r) : 64'(fs_r);
  assign mag_fw = fw_r[63] ? 64'(-fw_r) : 64'(fw_r);
  assign t_ge   = t_r >= start_r;
  assign t_diff = t_r - start_r;
  // During the interpolation multiply the second entry is still in the read register.
  assign sel_b   = (op_q_r == qcs_pkg::OP_RDB) ? rd_data_r : tab_b_r;
  assign b_ge_a  = sel_b >= tab_a_r;
  assign diff_ab = b_ge_a ? (sel_b - tab_a_r) : (tab_a_r - sel_b);
  assign seg_i   = {1'b0, prod_r[32 +: IW]};
  assign seg_m   = (IW + 1)'(2 * SINE_ENTRIES) - seg_i;
  assign rd_addr = (cmd.op == qcs_pkg::OP_RDB) ? ib_r : ia_r;
  assign ab_sum  = hi_r + {32'b0, prod_r[63:32]};
  assign aw_sum  = ab_sum;
  assign amp_rnd = prod_r[40:0] + 41'd524288;
  assign trav_sum = {1'b0, travel_r} + {13'b0, prod_r[51:16]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      qcs_pkg::OP_PH:     begin mul_a = {2'b0, t_diff};  mul_b = {1'b0, inv_dur_r}; end
      qcs_pkg::OP_SCALE:  begin mul_a = {2'b0, p_r};     mul_b = 33'(2 * SINE_ENTRIES); end
      qcs_pkg::OP_FS1:    begin mul_a = 34'(d_sw);       mul_b = {9'b0, spring_r}; end
      qcs_pkg::OP_FS2:    begin mul_a = 34'(d_v);        mul_b = {9'b0, damper_r}; end
      qcs_pkg::OP_TYRE:   begin mul_a = 34'(d_t);        mul_b = {9'b0, tyre_r}; end
      qcs_pkg::OP_INTERP: begin mul_a = {13'b0, diff_ab}; mul_b = {17'b0, f_r}; end
      qcs_pkg::OP_AMP:    begin mul_a = 34'(qcs_pkg::BUMP_AMP); mul_b = {12'b0, sine_r}; end
      qcs_pkg::OP_TRAV:   begin mul_a = {2'b0, speed_r}; mul_b = {13'b0, dt_r}; end
      qcs_pkg::OP_ABHI:   begin mul_a = {6'b0, mag_fs[59:32]}; mul_b = {1'b0, inv_sm_r}; end
      qcs_pkg::OP_ABLO:   begin mul_a = {2'b0, mag_fs[31:0]};  mul_b = {1'b0, inv_sm_r}; end
      qcs_pkg::OP_AWHI:   begin mul_a = {6'b0, mag_fw[59:32]}; mul_b = {1'b0, inv_usm_r}; end
      qcs_pkg::OP_AWLO:   begin mul_a = {2'b0, mag_fw[31:0]};  mul_b = {1'b0, inv_usm_r}; end
      qcs_pkg::OP_EUL0:   begin mul_a = {1'b0, mag33(body_vel_r)};  mul_b = {13'b0, dt_r}; end
      qcs_pkg::OP_EUL1:   begin mul_a = {1'b0, mag33(ab_r)};        mul_b = {13'b0, dt_r}; end
      qcs_pkg::OP_EUL2:   begin mul_a = {1'b0, mag33(wheel_vel_r)}; mul_b = {13'b0, dt_r}; end
      qcs_pkg::OP_EUL3:   begin mul_a = {1'b0, mag33(aw_r)};        mul_b = {13'b0, dt_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Control, configuration and state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_sm_r    <= 32'd11815591;
      inv_usm_r   <= 32'd114227853;
      spring_r    <= 24'd10300;
      damper_r    <= 24'd1000;
      tyre_r      <= 24'd18000;
      speed_r     <= 32'd65536;
      start_r     <= 32'd0;
      inv_dur_r   <= 32'd21845;
      body_pos_r  <= '0;
      body_vel_r  <= '0;
      wheel_pos_r <= '0;
      wheel_vel_r <= '0;
      travel_r    <= '0;
      out_valid_r <= 1'b0;
      op_q_r      <= qcs_pkg::OP_NONE;
    end else begin
      op_q_r <= cmd.op;
      if (cfg_we) begin
        case (qcs_pkg::cfg_idx_t'(cfg_index))
          qcs_pkg::CFG_INV_SPRUNG_MASS:   inv_sm_r  <= cfg_data;
          qcs_pkg::CFG_INV_UNSPRUNG_MASS: inv_usm_r <= cfg_data;
          qcs_pkg::CFG_SPRING_STIFFNESS:  spring_r  <= cfg_data[23:0];
          qcs_pkg::CFG_DAMPER_COEFF:      damper_r  <= cfg_data[23:0];
          qcs_pkg::CFG_TYRE_STIFFNESS:    tyre_r    <= cfg_data[23:0];
          qcs_pkg::CFG_TRAVEL_SPEED:      speed_r   <= cfg_data;
          qcs_pkg::CFG_BUMP_START_TIME:   start_r   <= cfg_data;
          qcs_pkg::CFG_BUMP_INV_DURATION: inv_dur_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        body_pos_r  <= nx0_r;
        body_vel_r  <= nx1_r;
        wheel_pos_r <= nx2_r;
        wheel_vel_r <= nx3_r;
        travel_r    <= trav_nx_r;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Multiplier, table read and write-back of the previous product.
  always_ff @(posedge clk) begin
    prod_r    <= mul_a * mul_b;
    rd_data_r <= sine_tab[rd_addr];
    if (cmd.load) begin
      t_r  <= in_chan.sample_time;
      dt_r <= in_chan.time_step;
    end
    if (cmd.commit) begin
      o_bp_r <= nx0_r;
      o_bv_r <= nx1_r;
      o_ba_r <= ab_r;
      o_wp_r <= nx2_r;
      o_wv_r <= nx3_r;
      o_wa_r <= aw_r;
      o_zr_r <= zr_r;
      o_td_r <= trav_nx_r;
    end
    case (op_q_r)
      qcs_pkg::OP_PH: begin
        active_r <= t_ge && (prod_r[63:32] == 32'd0);
        p_r      <= prod_r[31:0];
      end
      qcs_pkg::OP_SCALE: begin
        f_r <= prod_r[31:16];
        if (seg_i < (IW + 1)'(SINE_ENTRIES)) begin
          ia_r <= AW'(seg_i);
          ib_r <= AW'(seg_i + 1'b1);
        end else begin
          ia_r <= AW'(seg_m);
          ib_r <= AW'(seg_m - 1'b1);
        end
      end
      qcs_pkg::OP_RDA:    tab_a_r <= rd_data_r;
      qcs_pkg::OP_RDB:    tab_b_r <= rd_data_r;
      qcs_pkg::OP_INTERP: sine_r <= b_ge_a ? (tab_a_r + prod_r[36:16])
                                           : (tab_a_r - prod_r[36:16]);
      qcs_pkg::OP_AMP:    zr_r <= active_r ? (32'sd0 - $signed({11'b0, amp_rnd[40:20]}))
                                           : 32'sd0;
      qcs_pkg::OP_FS1:    fs_r <= prod_r[63:0];
      qcs_pkg::OP_FS2:    fs_r <= fs_r + prod_r[63:0];
      qcs_pkg::OP_TYRE:   fw_r <= fs_r - prod_r[63:0];
      qcs_pkg::OP_TRAV:   trav_nx_r <= trav_sum[48] ? '1 : trav_sum[47:0];
      qcs_pkg::OP_ABHI:   hi_r <= prod_r[63:0];
      qcs_pkg::OP_AWHI:   hi_r <= prod_r[63:0];
      // The body force enters negated, so its sign flips.
      qcs_pkg::OP_ABLO:   ab_r <= sat32(fs_r[63] ? $signed(ab_sum) : -$signed(ab_sum));
      qcs_pkg::OP_AWLO:   aw_r <= sat32(fw_r[63] ? -$signed(aw_sum) : $signed(aw_sum));
      qcs_pkg::OP_EUL0:   nx0_r <= euler_add(body_pos_r, body_vel_r[31], prod_r[51:20]);
      qcs_pkg::OP_EUL1:   nx1_r <= euler_add(body_vel_r, ab_r[31], prod_r[51:20]);
      qcs_pkg::OP_EUL2:   nx2_r <= euler_add(wheel_pos_r, wheel_vel_r[31], prod_r[51:20]);
      qcs_pkg::OP_EUL3:   nx3_r <= euler_add(wheel_vel_r, aw_r[31], prod_r[51:20]);
      default: ;
    endcase
  end

  assign sts.slot_free = !out_valid_r || out_chan.ready;

  assign out_chan.valid              = out_valid_r;
  assign out_chan.body_position      = o_bp_r;
  assign out_chan.body_velocity      = o_bv_r;
  assign out_chan.body_acceleration  = o_ba_r;
  assign out_chan.wheel_position     = o_wp_r;
  assign out_chan.wheel_velocity     = o_wv_r;
  assign out_chan.wheel_acceleration = o_wa_r;
  assign out_chan.road_height        = o_zr_r;
  assign out_chan.travel_distance    = o_td_r;

endmodule

`default_nettype wire

// ----- src/quarter_car_suspension_step_core.sv -----
// Each accepted item runs through 16 passes of the single shared multiplier and two
// table reads, then write-back and hand-over to the output register, before the core
// returns to idle; no new item is taken until the last one is handed over, which waits
// while the output register is full. A finished result waits in the output register while the next item is taken.
// Reset (synchronous, rst_n low) zeroes the state and loads the default registers.
// ----------------------------------------------------------------------------
// quarter_car_suspension_step_core: quarter-car suspension Euler step
// One explicit Euler step of a body/wheel model over a half-sine road bump.
// ----------------------------------------------------------------------------
`default_nettype none

module quarter_car_suspension_step_core #(
  parameter int SINE_ENTRIES = 256
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [31:0] cfg_data,
  qcs_in_if.sink     in_chan,
  qcs_out_if.source  out_chan
);

  qcs_pkg::ctrl_cmd_t cmd;
  qcs_pkg::ctrl_sts_t sts;

  qcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qcs_datapath #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cmd       (cmd),
    .sts       (sts)
  );

  // One item at a time: after an accepted transaction the input stays closed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input accepted while a step is in progress");

  // A new result appears only by a commit of the sequencer.
  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.commit))
    else $error("result valid without a commit");

  // The bump only ever lowers the road.
  a_road_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.road_height[31] || out_chan.road_height == 32'd0))
    else $error("positive road height");

endmodule

`default_nettype wire
